### hdl/tcgr_pkg.sv
// Shared types and constants of the text cell glyph rasterizer.
`timescale 1ns / 1ps
package tcgr_pkg;

    // Default font geometry
    localparam int GLYPH_LINES_DEF = 16;
    localparam int GLYPH_COUNT_DEF = 256;

    // Field widths fixed by the stream format
    localparam int GIDX_W  = 8;
    localparam int GLINE_W = 4;
    localparam int FBYTE_W = 8;
    localparam int CELL_W  = 8;
    localparam int COLOR_W = 32;
    localparam int PIX_N   = 9;
    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = PIX_N * COLOR_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_COL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ROW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS_IN_USE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE    = 3'd4;

    localparam logic              CURSOR_ENABLE_RST  = 1'b1;
    localparam logic [CELL_W-1:0] CURSOR_COL_RST     = 8'd0;
    localparam logic [CELL_W-1:0] CURSOR_ROW_RST     = 8'd0;
    localparam logic [CELL_W-1:0] COLUMNS_IN_USE_RST = 8'd80;
    localparam logic [CELL_W-1:0] ROWS_IN_USE_RST    = 8'd25;

    // Item kinds carried on s_tuser
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    // Color shaping
    localparam logic [8:0]        BOLD_LIFT       = 9'd63;
    localparam logic [7:0]        BYTE_MAX        = 8'd255;
    localparam logic [GIDX_W-1:0] LINE_DRAW_FIRST = 8'hB0;
    localparam logic [GIDX_W-1:0] LINE_DRAW_LAST  = 8'hDF;

    typedef logic [PIX_N-1:0][COLOR_W-1:0] pix_row_t;

    // Per-item control decided at the input register
    typedef struct packed {
        logic render_ok;   // render, glyph in font, cell on grid
        logic solid;       // whole line in foreground
        logic line_draw;   // ninth pixel repeats bit 0
        logic bold;
    } shade_ctrl_t;

endpackage

### hdl/tcgr_font_store.sv
// Font bitmap memory: one write port, one registered read port.
`timescale 1ns / 1ps
module tcgr_font_store
    import tcgr_pkg::*;
#(
    parameter int DEPTH  = GLYPH_COUNT_DEF * GLYPH_LINES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [FBYTE_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [FBYTE_W-1:0] rd_data
);

    logic [FBYTE_W-1:0] mem [DEPTH];
    logic [FBYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the read word while the item waits downstream
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/tcgr_shade.sv
// Pixel composer: glyph bits and colors to nine pixel colors.
`timescale 1ns / 1ps
module tcgr_shade
    import tcgr_pkg::*;
(
    input  shade_ctrl_t        ctrl,
    input  logic [FBYTE_W-1:0] glyph_bits,
    input  logic [COLOR_W-1:0] fg_color,
    input  logic [COLOR_W-1:0] bg_color,
    output pix_row_t           pix,
    output logic               drawn
);

    function automatic logic [7:0] lift_byte(input logic [7:0] v);
        logic [8:0] sum;
        begin
            sum = {1'b0, v} + BOLD_LIFT;
            lift_byte = sum[8] ? BYTE_MAX : sum[7:0];
        end
    endfunction

    logic [COLOR_W-1:0] fg_eff;
    logic [COLOR_W-1:0] last_color;

    always_comb begin
        if (ctrl.bold) begin
            fg_eff = {8'd0, lift_byte(fg_color[23:16]), lift_byte(fg_color[15:8]),
                      lift_byte(fg_color[7:0])};
        end else begin
            fg_eff = fg_color;
        end
    end

    always_comb begin
        last_color = (ctrl.line_draw && glyph_bits[0]) ? fg_eff : bg_color;
        for (int k = 0; k < 8; k++) begin
            if (!ctrl.render_ok) begin
                pix[k] = '0;
            end else begin
                // Most significant glyph bit is the leftmost pixel
                pix[k] = (ctrl.solid || glyph_bits[7-k]) ? fg_eff : bg_color;
            end
        end
        if (!ctrl.render_ok) begin
            pix[8] = '0;
        end else begin
            pix[8] = ctrl.solid ? fg_eff : last_color;
        end
    end

    assign drawn = ctrl.render_ok;

endmodule

### hdl/text_cell_glyph_rasterizer_core.sv
// An accepted item goes through the read stage and the output register to m_*.
// Throughput: one item per cycle unless m_tready stalls; one font read per item.
// s_tready drops only while both the read stage and the output register are full.
// Reset (aresetn low, synchronous) empties both stages and loads register defaults.
// Font memory contents are not cleared by reset and are undefined until loaded.
`timescale 1ns / 1ps
module text_cell_glyph_rasterizer_core
    import tcgr_pkg::*;
#(
    parameter int GLYPH_LINES = GLYPH_LINES_DEF,
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata, low bit up: glyph_index[7:0], glyph_line[11:8], font_byte[19:12],
    // cell_col[27:20], cell_row[35:28], fg_color[67:36], bg_color[99:68],
    // bold[100], underline[101], zero pad[103:102]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tuser,    // op
    // m_tdata, low bit up: pix0[31:0] .. pix8[287:256]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic                  m_tuser,    // drawn
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH  = GLYPH_COUNT * GLYPH_LINES;
    localparam int ADDR_W = $clog2(DEPTH);

    // Configuration registers
    logic              cursor_enable_reg;
    logic [CELL_W-1:0] cursor_col_reg;
    logic [CELL_W-1:0] cursor_row_reg;
    logic [CELL_W-1:0] columns_reg;
    logic [CELL_W-1:0] rows_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_enable_reg <= CURSOR_ENABLE_RST;
            cursor_col_reg    <= CURSOR_COL_RST;
            cursor_row_reg    <= CURSOR_ROW_RST;
            columns_reg       <= COLUMNS_IN_USE_RST;
            rows_reg          <= ROWS_IN_USE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CURSOR_ENABLE:  cursor_enable_reg <= cfg_data[0];
                CFG_CURSOR_COL:     cursor_col_reg    <= cfg_data;
                CFG_CURSOR_ROW:     cursor_row_reg    <= cfg_data;
                CFG_COLUMNS_IN_USE: columns_reg       <= cfg_data;
                CFG_ROWS_IN_USE:    rows_reg          <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input field unpacking
    logic [GIDX_W-1:0]  in_gidx;
    logic [GLINE_W-1:0] in_gline;
    logic [FBYTE_W-1:0] in_fbyte;
    logic [CELL_W-1:0]  in_col;
    logic [CELL_W-1:0]  in_row;
    logic [COLOR_W-1:0] in_fg;
    logic [COLOR_W-1:0] in_bg;
    logic               in_bold;
    logic               in_uline;

    assign in_gidx  = s_tdata[7:0];
    assign in_gline = s_tdata[11:8];
    assign in_fbyte = s_tdata[19:12];
    assign in_col   = s_tdata[27:20];
    assign in_row   = s_tdata[35:28];
    assign in_fg    = s_tdata[67:36];
    assign in_bg    = s_tdata[99:68];
    assign in_bold  = s_tdata[100];
    assign in_uline = s_tdata[101];

    // Handshake and stage control
    logic a_valid_reg, a_valid_next;
    logic b_valid_reg, b_valid_next;
    logic b_ready;
    logic s_xfer;
    logic a_advance;

    assign b_ready   = !b_valid_reg || m_tready;
    assign s_tready  = !a_valid_reg || b_ready;
    assign s_xfer    = s_tvalid && s_tready;
    assign a_advance = a_valid_reg && b_ready;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_xfer) begin
            a_valid_next = 1'b1;
        end else if (b_ready) begin
            a_valid_next = 1'b0;
        end
        b_valid_next = b_valid_reg;
        if (a_advance) begin
            b_valid_next = 1'b1;
        end else if (m_tready) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Item decode at the input side
    logic              in_font;
    logic              on_grid;
    logic              cursor_here;
    logic [ADDR_W-1:0] glyph_addr;
    shade_ctrl_t       ctrl_next;

    always_comb begin
        in_font     = (int'(in_gidx) < GLYPH_COUNT) && (int'(in_gline) < GLYPH_LINES);
        on_grid     = (in_col < columns_reg) && (in_row < rows_reg);
        cursor_here = cursor_enable_reg && (in_col == cursor_col_reg)
                      && (in_row == cursor_row_reg);
        glyph_addr  = ADDR_W'(int'(in_gidx) * GLYPH_LINES + int'(in_gline));
        ctrl_next.render_ok = (s_tuser == OP_RENDER) && in_font && on_grid;
        ctrl_next.solid     = (cursor_here && (int'(in_gline) >= GLYPH_LINES - 2))
                              || (in_uline && (int'(in_gline) == GLYPH_LINES - 2));
        ctrl_next.line_draw = (in_gidx >= LINE_DRAW_FIRST) && (in_gidx <= LINE_DRAW_LAST);
        ctrl_next.bold      = in_bold;
    end

    logic [FBYTE_W-1:0] glyph_bits;

    tcgr_font_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_font_store (
        .aclk    (aclk),
        .wr_en   (s_xfer && (s_tuser == OP_LOAD) && in_font),
        .wr_addr (glyph_addr),
        .wr_data (in_fbyte),
        .rd_en   (s_xfer),
        .rd_addr (glyph_addr),
        .rd_data (glyph_bits)
    );

    // Read stage payload
    shade_ctrl_t        a_ctrl_reg;
    logic [COLOR_W-1:0] a_fg_reg;
    logic [COLOR_W-1:0] a_bg_reg;

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            a_ctrl_reg <= ctrl_next;
            a_fg_reg   <= in_fg;
            a_bg_reg   <= in_bg;
        end
    end

    pix_row_t pix_next;
    logic     drawn_next;

    tcgr_shade u_shade (
        .ctrl       (a_ctrl_reg),
        .glyph_bits (glyph_bits),
        .fg_color   (a_fg_reg),
        .bg_color   (a_bg_reg),
        .pix        (pix_next),
        .drawn      (drawn_next)
    );

    // Output register
    pix_row_t b_pix_reg;
    logic     b_drawn_reg;

    always_ff @(posedge aclk) begin
        if (a_advance) begin
            b_pix_reg   <= pix_next;
            b_drawn_reg <= drawn_next;
        end
    end

    assign m_tvalid = b_valid_reg;
    assign m_tdata  = b_pix_reg;
    assign m_tuser  = b_drawn_reg;

endmodule

### hdl/tcgr_checker.sv
// Port-level checks of the rasterizer core, bound to the top level.
`timescale 1ns / 1ps
module tcgr_checker
    import tcgr_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata,
    input logic                  m_tuser
);

    // A stalled result holds its pixels
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Loads and off-grid cells give all-zero pixels
    a_undrawn_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("undrawn result with nonzero pixels");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // An empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind text_cell_glyph_rasterizer_core tcgr_checker u_tcgr_checker (.*);

### tb/sv/tb_text_cell_glyph_rasterizer_core.sv
// Self-checking testbench for the text cell glyph rasterizer core.
`timescale 1ns / 1ps
module tb_text_cell_glyph_rasterizer_core;
    import tcgr_pkg::*;

    localparam int FONT_DEPTH      = GLYPH_COUNT_DEF * GLYPH_LINES_DEF;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 240;

    // One input item as it travels on s_tdata, first field in the top bits
    typedef struct packed {
        logic [1:0]         pad;
        logic               underline;
        logic               bold;
        logic [COLOR_W-1:0] bg_color;
        logic [COLOR_W-1:0] fg_color;
        logic [CELL_W-1:0]  cell_row;
        logic [CELL_W-1:0]  cell_col;
        logic [FBYTE_W-1:0] font_byte;
        logic [GLINE_W-1:0] glyph_line;
        logic [GIDX_W-1:0]  glyph_index;
    } cell_item_t;

    typedef struct packed {
        pix_row_t pix;
        logic     drawn;
    } cell_line_t;

    typedef enum logic [1:0] {
        JOB_ITEM,
        JOB_CFG,
        JOB_DRAIN,
        JOB_HOLD_OFF
    } job_kind_t;

    typedef struct {
        job_kind_t             kind;
        logic                  op;
        cell_item_t            item;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
    } job_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = OP_LOAD;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    job_t        jobs[$];
    cell_line_t  lines_due[$];
    logic [11:0] font_addrs[$];
    bit          font_loaded[FONT_DEPTH];

    // Predictor state: font contents and register copies
    logic [7:0]        font_copy[FONT_DEPTH];
    logic              cursor_en_q   = CURSOR_ENABLE_RST;
    logic [CELL_W-1:0] cursor_col_q  = CURSOR_COL_RST;
    logic [CELL_W-1:0] cursor_row_q  = CURSOR_ROW_RST;
    logic [CELL_W-1:0] columns_q     = COLUMNS_IN_USE_RST;
    logic [CELL_W-1:0] rows_q        = ROWS_IN_USE_RST;

    int tx_wait;
    int rx_wait;
    int hold_left;
    bit tx_calm;
    bit rx_calm;
    int hold_off_asked = 0;
    int hold_off_done  = 0;
    int mismatch_count = 0;

    text_cell_glyph_rasterizer_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic int draw_gap(ref bit calm);
        if ($urandom_range(0, 49) == 0) calm = ~calm;
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    // Store a font byte on a load; build the nine pixels of one glyph line on a render
    function automatic cell_line_t rasterize_cell(logic op, cell_item_t it);
        cell_line_t  res;
        logic [7:0]  bits;
        logic [31:0] fg;
        logic [8:0]  lifted;
        logic        solid;
        logic        cursor_here;
        res = '0;
        if (op == OP_LOAD) begin
            font_copy[{it.glyph_index, it.glyph_line}] = it.font_byte;
            return res;
        end
        if (it.cell_col >= columns_q || it.cell_row >= rows_q) return res;
        bits = font_copy[{it.glyph_index, it.glyph_line}];
        fg = it.fg_color;
        if (it.bold) begin
            fg = '0;
            for (int b = 0; b < 3; b++) begin
                lifted = {1'b0, it.fg_color[8*b +: 8]} + BOLD_LIFT;
                fg[8*b +: 8] = (lifted > {1'b0, BYTE_MAX}) ? BYTE_MAX : lifted[7:0];
            end
        end
        cursor_here = cursor_en_q && it.cell_col == cursor_col_q && it.cell_row == cursor_row_q;
        solid = (cursor_here && it.glyph_line >= GLINE_W'(GLYPH_LINES_DEF - 2))
              || (it.underline && it.glyph_line == GLINE_W'(GLYPH_LINES_DEF - 2));
        for (int k = 0; k < 8; k++)
            res.pix[k] = (solid || bits[7-k]) ? fg : it.bg_color;
        if (solid || (it.glyph_index >= LINE_DRAW_FIRST && it.glyph_index <= LINE_DRAW_LAST
                      && bits[0]))
            res.pix[8] = fg;
        else
            res.pix[8] = it.bg_color;
        res.drawn = 1'b1;
        return res;
    endfunction

    task automatic add_load(input logic [7:0] gidx, input logic [3:0] gline,
                            input logic [7:0] fbyte);
        job_t j;
        j.kind = JOB_ITEM;
        j.op = OP_LOAD;
        j.cfg_idx = '0;
        j.cfg_val = '0;
        // unused fields carry noise
        j.item = {2'b00, 1'($urandom), 1'($urandom), 32'($urandom), 32'($urandom),
                  8'($urandom), 8'($urandom), fbyte, gline, gidx};
        jobs.push_back(j);
        if (!font_loaded[{gidx, gline}]) begin
            font_loaded[{gidx, gline}] = 1'b1;
            font_addrs.push_back({gidx, gline});
        end
    endtask

    task automatic add_render(input logic [7:0] gidx, input logic [3:0] gline,
                              input logic [7:0] col, input logic [7:0] row,
                              input logic [31:0] fg, input logic [31:0] bg,
                              input logic bold, input logic uline);
        job_t j;
        j.kind = JOB_ITEM;
        j.op = OP_RENDER;
        j.cfg_idx = '0;
        j.cfg_val = '0;
        j.item = {2'b00, uline, bold, bg, fg, row, col, 8'($urandom), gline, gidx};
        jobs.push_back(j);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        job_t j;
        j.kind = JOB_CFG;
        j.op = OP_LOAD;
        j.item = '0;
        j.cfg_idx = idx;
        j.cfg_val = val;
        jobs.push_back(j);
    endtask

    task automatic add_marker(input job_kind_t kind);
        job_t j;
        j.kind = kind;
        j.op = OP_LOAD;
        j.item = '0;
        j.cfg_idx = '0;
        j.cfg_val = '0;
        jobs.push_back(j);
    endtask

    initial begin : fill_jobs
        int          cols;
        int          rows;
        int          ccol;
        int          crow;
        bit          cen;
        int          pick;
        logic [11:0] addr;
        logic [7:0]  gidx;
        logic [3:0]  gline;
        int          col;
        int          row;
        logic [31:0] fg;

        // Font lines used by the directed renders
        add_load(8'h00, 4'd0, 8'hFF);
        add_load(8'hFF, 4'd15, 8'h81);
        add_load(8'hB0, 4'd14, 8'h01);
        add_load(8'hDF, 4'd15, 8'hA5);
        add_load(8'hAF, 4'd3, 8'h01);
        add_load(8'hE0, 4'd3, 8'h01);
        add_load(8'h41, 4'd5, 8'h3C);

        // Registers at reset: cursor on at (0,0), 80 x 25 grid
        add_render(8'h00, 4'd0, 8'd0, 8'd0, 32'hFFFFFFFF, 32'h00000000, 1'b0, 1'b0);
        add_render(8'hB0, 4'd14, 8'd0, 8'd0, 32'hFFC1C0FF, 32'h12345678, 1'b1, 1'b0);
        add_render(8'hFF, 4'd15, 8'd0, 8'd0, 32'h80402010, 32'hFFFFFFFF, 1'b0, 1'b1);
        add_render(8'hB0, 4'd14, 8'd79, 8'd24, 32'h00AA5500, 32'h00000000, 1'b0, 1'b1);
        add_render(8'hDF, 4'd15, 8'd79, 8'd24, 32'h00000000, 32'hFFFFFFFF, 1'b1, 1'b0);
        add_render(8'hAF, 4'd3, 8'd40, 8'd12, 32'hFF00FF00, 32'h00FF00FF, 1'b0, 1'b0);
        add_render(8'hE0, 4'd3, 8'd40, 8'd12, 32'hFF00FF00, 32'h00FF00FF, 1'b0, 1'b0);
        add_render(8'h41, 4'd5, 8'd1, 8'd0, 32'h0F0F0F0F, 32'hF0F0F0F0, 1'b0, 1'b1);
        add_render(8'h00, 4'd0, 8'd80, 8'd0, 32'hFFFFFFFF, 32'h00000000, 1'b0, 1'b0);
        add_render(8'h00, 4'd0, 8'd0, 8'd25, 32'hFFFFFFFF, 32'h00000000, 1'b0, 1'b0);
        add_render(8'h00, 4'd0, 8'd255, 8'd255, 32'hFFFFFFFF, 32'h00000000, 1'b0, 1'b0);
        add_cfg(CFG_CURSOR_ENABLE, 8'd0);
        add_render(8'hFF, 4'd15, 8'd0, 8'd0, 32'h80402010, 32'hFFFFFFFF, 1'b0, 1'b0);
        // zero columns puts every cell off the grid
        add_cfg(CFG_COLUMNS_IN_USE, 8'd0);
        add_render(8'h00, 4'd0, 8'd0, 8'd0, 32'hFFFFFFFF, 32'h00000000, 1'b0, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin cen = 1; ccol = 3;   crow = 7;   cols = 80;  rows = 25;  end
                1: begin cen = 1; ccol = 254; crow = 254; cols = 255; rows = 255; end
                2: begin cen = 1; ccol = 0;   crow = 0;   cols = 1;   rows = 1;   end
                3: begin cen = 0; ccol = 255; crow = 255; cols = 40;  rows = 12;  end
                default: begin
                    cen  = $urandom_range(0, 1);
                    cols = $urandom_range(1, 255);
                    rows = $urandom_range(1, 255);
                    ccol = $urandom_range(0, cols - 1);
                    crow = $urandom_range(0, rows - 1);
                end
            endcase
            add_cfg(CFG_CURSOR_ENABLE, {7'd0, cen});
            add_cfg(CFG_CURSOR_COL, 8'(ccol));
            add_cfg(CFG_CURSOR_ROW, 8'(crow));
            add_cfg(CFG_COLUMNS_IN_USE, 8'(cols));
            add_cfg(CFG_ROWS_IN_USE, 8'(rows));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == 40 && (p == 2 || p == 6)) add_marker(JOB_HOLD_OFF);
                if (i == 120 && p == 4) add_marker(JOB_DRAIN);
                if ($urandom_range(0, 99) < 35) begin
                    // bias loads toward line-drawing glyphs and the bottom lines
                    gidx = ($urandom_range(0, 9) < 3) ? 8'($urandom_range(8'hB0, 8'hDF))
                                                      : 8'($urandom);
                    gline = ($urandom_range(0, 9) < 3) ? 4'($urandom_range(14, 15))
                                                       : 4'($urandom);
                    add_load(gidx, gline, 8'($urandom));
                end else begin
                    addr = font_addrs[$urandom_range(0, font_addrs.size() - 1)];
                    pick = $urandom_range(0, 99);
                    if (pick < 20) begin
                        col = ccol;
                        row = crow;
                    end else if (pick < 25) begin
                        col = $urandom_range(cols, 255);
                        row = $urandom_range(0, 255);
                    end else if (pick < 30) begin
                        col = $urandom_range(0, 255);
                        row = $urandom_range(rows, 255);
                    end else begin
                        col = $urandom_range(0, cols - 1);
                        row = $urandom_range(0, rows - 1);
                    end
                    pick = $urandom_range(0, 19);
                    fg = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFFFFFF : 32'($urandom);
                    add_render(addr[11:4], addr[3:0], 8'(col), 8'(row), fg, 32'($urandom),
                               1'($urandom), 1'($urandom));
                end
            end
        end
    end

    // Sender: present items, write registers when drained, raise hold-off requests
    always @(posedge aclk) begin : drive_items
        job_t job;
        logic hold;
        logic nxt_valid;
        logic nxt_cfg_wr;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            cfg_wr_en <= 1'b0;
            tx_wait = 0;
        end else begin
            hold = s_tvalid && !s_tready;
            nxt_valid = hold;
            nxt_cfg_wr = 1'b0;
            if (s_tvalid && s_tready)
                lines_due.push_back(rasterize_cell(s_tuser, cell_item_t'(s_tdata)));
            if (!hold) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (jobs.size() > 0) begin
                    job = jobs[0];
                    case (job.kind)
                        JOB_ITEM: begin
                            s_tdata <= job.item;
                            s_tuser <= job.op;
                            nxt_valid = 1'b1;
                            void'(jobs.pop_front());
                            tx_wait = draw_gap(tx_calm);
                        end
                        JOB_CFG: begin
                            if (lines_due.size() == 0) begin
                                nxt_cfg_wr = 1'b1;
                                cfg_index <= job.cfg_idx;
                                cfg_data  <= job.cfg_val;
                                case (job.cfg_idx)
                                    CFG_CURSOR_ENABLE:  cursor_en_q  = job.cfg_val[0];
                                    CFG_CURSOR_COL:     cursor_col_q = job.cfg_val;
                                    CFG_CURSOR_ROW:     cursor_row_q = job.cfg_val;
                                    CFG_COLUMNS_IN_USE: columns_q    = job.cfg_val;
                                    CFG_ROWS_IN_USE:    rows_q       = job.cfg_val;
                                    default: ;
                                endcase
                                void'(jobs.pop_front());
                            end
                        end
                        JOB_DRAIN: begin
                            if (lines_due.size() == 0) void'(jobs.pop_front());
                        end
                        JOB_HOLD_OFF: begin
                            hold_off_asked <= hold_off_asked + 1;
                            void'(jobs.pop_front());
                        end
                        default: ;
                    endcase
                end
            end
            s_tvalid  <= nxt_valid;
            cfg_wr_en <= nxt_cfg_wr;
        end
    end

    // Receiver: check each transfer against the oldest expected line, pace m_tready
    always @(posedge aclk) begin : collect_lines
        cell_line_t want;
        pix_row_t   got_pix;
        logic       rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (lines_due.size() == 0) begin
                    $error("unexpected result transfer, drawn=%0d", m_tuser);
                    mismatch_count++;
                end else begin
                    want = lines_due.pop_front();
                    got_pix = m_tdata;
                    for (int k = 0; k < PIX_N; k++) begin
                        if (got_pix[k] !== want.pix[k]) begin
                            $error("pix%0d: expected %08h, got %08h", k, want.pix[k],
                                   got_pix[k]);
                            mismatch_count++;
                        end
                    end
                    if (m_tuser !== want.drawn) begin
                        $error("drawn: expected %0d, got %0d", want.drawn, m_tuser);
                        mismatch_count++;
                    end
                end
                rx_wait = draw_gap(rx_calm);
            end
            if (hold_off_done != hold_off_asked) begin
                hold_off_done++;
                hold_left = HOLD_OFF_CYCLES;
            end
            rdy = 1'b0;
            if (hold_left > 0)
                hold_left--;
            else if (rx_wait > 0)
                rx_wait--;
            else
                rdy = 1'b1;
            m_tready <= rdy;
        end
    end

    initial begin : run_ctrl
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        do
            @(posedge aclk);
        while (jobs.size() != 0 || s_tvalid || lines_due.size() != 0);
        // allow any stray transfer to show up
        repeat (6) @(posedge aclk);
        if (mismatch_count == 0 && lines_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
